// ----- rtl/lap3x3_pkg.sv -----
// shared constants and types of the 3x3 laplacian filter
package lap3x3_pkg;

	localparam int MAX_SIDE_DEF = 1024;
	localparam int SIDE_RST     = 256;
	localparam int CFG_W        = 11;
	localparam int PIX_W        = 8;
	localparam int FIFO_DEPTH   = 4;

	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// per-result control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} lap3x3_ctl_t;

	typedef struct packed {
		pix_t filtered;
		logic frame_last;
	} lap3x3_res_t;

endpackage

// ----- rtl/lap3x3_if.sv -----
// valid/ready stream interfaces for pixels in and filtered results out
interface lap3x3_in_if import lap3x3_pkg::*; ();
	logic valid;
	logic ready;
	logic command;
	pix_t pixel;

	modport source(output valid, command, pixel, input ready);
	modport sink(input valid, command, pixel, output ready);
endinterface

interface lap3x3_out_if import lap3x3_pkg::*; ();
	logic valid;
	logic ready;
	pix_t filtered;
	logic frame_last;

	modport source(output valid, filtered, frame_last, input ready);
	modport sink(input valid, filtered, frame_last, output ready);
endinterface

// ----- rtl/laplacian_3x3_filter.sv -----
// 8-neighbor laplacian over a square 8-bit raster image, results clamped to 0..255
// One transaction is taken per clock: a pixel or a flush tick. Each pixel is written into two
// row buffers of MAX_SIDE entries (one read and one write port each) and shifted into a 3x3
// window; the result for a raster position is emitted when the pixel one row plus one column
// past it is accepted and is queued from stage 2, so a frame of side S needs S+1 flush
// transactions after its last pixel to drain (none for a side of one). The row buffers need
// no clearing after reset: border positions ignore whatever they hold. The input stalls only
// when four results are queued or in flight without being taken. Writing cfg_data starts a
// new frame; a side of zero acts as one and a side above MAX_SIDE acts as MAX_SIDE. Pixels
// past the end of the frame and flushes before it is complete are taken and dropped.
module laplacian_3x3_filter import lap3x3_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	lap3x3_in_if.sink        stream,
	lap3x3_out_if.source     result
);

	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int AW       = $clog2(MAX_SIDE);
	localparam int LAG_W    = $clog2(MAX_SIDE + 2);
	localparam int RST_SIDE = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;
	localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
	localparam int FCNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W    = $clog2(FIFO_DEPTH + 3);

	logic [SIDE_W-1:0] side_q;
	logic [SIDE_W-1:0] side_new;
	logic [AW-1:0]     side_m1;
	logic [AW-1:0]     in_col_q;
	logic [SIDE_W-1:0] in_row_q;
	logic [AW-1:0]     sh_col_q;
	logic [LAG_W-1:0]  lag_q;
	logic [AW-1:0]     out_col_q;
	logic [AW-1:0]     out_row_q;

	logic accept, is_flush, in_done, take_pix, take_flush, shift;
	logic primed, last_in, emit, last_out;
	lap3x3_ctl_t ctl_nxt;

	// stage 1: row buffer read data and the incoming column
	logic        shift_s1;
	lap3x3_ctl_t ctl_s1;
	pix_t        pix_s1;
	logic [AW-1:0] col_s1;
	pix_t        a_s1;
	pix_t        b_s1;

	// stage 2: window holds the neighborhood of the result position
	lap3x3_ctl_t ctl_s2;
	pix_t        win_q [3][3];

	pix_t row1_mem [MAX_SIDE];
	pix_t row2_mem [MAX_SIDE];

	logic signed [11:0] acc;
	pix_t        lap;

	lap3x3_res_t       fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FCNT_W-1:0]  cnt_q;
	logic [OCC_W-1:0]   occ;
	logic               push, pop;

	// clip the written side into 1..MAX_SIDE
	always_comb begin
		if (cfg_data == '0) begin
			side_new = SIDE_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
			side_new = SIDE_W'(MAX_SIDE);
		end else begin
			side_new = SIDE_W'(cfg_data);
		end
	end

	assign side_m1    = AW'(side_q - SIDE_W'(1));
	assign accept     = stream.valid && stream.ready;
	assign is_flush   = stream.command == CMD_FLUSH;
	assign in_done    = in_row_q == side_q;
	assign take_pix   = accept && !is_flush && !in_done;
	assign take_flush = accept && is_flush && in_done;
	assign shift      = take_pix || take_flush;
	// window lags the input by one row plus one pixel
	assign primed     = lag_q == (LAG_W'(side_q) + LAG_W'(1));
	assign last_in    = (in_row_q == SIDE_W'(side_m1)) && (in_col_q == side_m1);
	assign emit       = take_flush || (take_pix && (primed || last_in));
	assign last_out   = (out_row_q == side_m1) && (out_col_q == side_m1);

	always_comb begin
		ctl_nxt.emit   = emit;
		ctl_nxt.last   = last_out;
		ctl_nxt.top    = out_row_q == '0;
		ctl_nxt.bottom = out_row_q == side_m1;
		ctl_nxt.left   = out_col_q == '0;
		ctl_nxt.right  = out_col_q == side_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= SIDE_W'(RST_SIDE);
			in_col_q  <= '0;
			in_row_q  <= '0;
			sh_col_q  <= '0;
			lag_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			side_q    <= side_new;
			in_col_q  <= '0;
			in_row_q  <= '0;
			sh_col_q  <= '0;
			lag_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (emit && last_out) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			sh_col_q  <= '0;
			lag_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (take_pix) begin
				if (in_col_q == side_m1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + SIDE_W'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end
			if (shift) begin
				sh_col_q <= (sh_col_q == side_m1) ? '0 : sh_col_q + AW'(1);
				if (!primed) begin
					lag_q <= lag_q + LAG_W'(1);
				end
			end
			if (emit) begin
				if (out_col_q == side_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + AW'(1);
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
		end
	end

	// row buffers: read on each shift, written back in the following cycle from stage 1
	always_ff @(posedge clk) begin
		if (shift) begin
			a_s1 <= row1_mem[sh_col_q];
			b_s1 <= row2_mem[sh_col_q];
		end
		if (shift_s1) begin
			row1_mem[col_s1] <= pix_s1;
			row2_mem[col_s1] <= a_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= stream.pixel;
		col_s1 <= sh_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			ctl_s1   <= '0;
			ctl_s2   <= '0;
		end else begin
			shift_s1 <= shift;
			ctl_s1   <= ctl_nxt;
			ctl_s2   <= ctl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= b_s1;
			win_q[1][2] <= a_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	// neighbors outside the image count as zero
	always_comb begin
		logic keep;
		acc = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				keep = !((r == 0 && ctl_s2.top) || (r == 2 && ctl_s2.bottom) ||
					(c == 0 && ctl_s2.left) || (c == 2 && ctl_s2.right));
				if (keep) begin
					if (r == 1 && c == 1) begin
						acc = acc - signed'({1'b0, win_q[r][c], 3'b000});
					end else begin
						acc = acc + signed'({4'b0000, win_q[r][c]});
					end
				end
			end
		end
		// a one-pixel image has no neighbors, so its response is always zero
		if (ctl_s2.top && ctl_s2.bottom) begin
			lap = '0;
		end else if (acc < 12'sd0) begin
			lap = '0;
		end else if (acc > 12'sd255) begin
			lap = 8'hFF;
		end else begin
			lap = acc[7:0];
		end
	end

	// result queue
	assign push = ctl_s2.emit;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{filtered: lap, frame_last: ctl_s2.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FCNT_W'(1);
			end
		end
	end

	assign result.valid      = cnt_q != '0;
	assign result.filtered   = fifo_q[rd_ptr_q].filtered;
	assign result.frame_last = fifo_q[rd_ptr_q].frame_last;

	// room for every result already on its way
	assign occ          = OCC_W'(cnt_q) + OCC_W'(ctl_s1.emit) + OCC_W'(ctl_s2.emit);
	assign stream.ready = occ < OCC_W'(FIFO_DEPTH);

endmodule

// ----- rtl/lap3x3_checker.sv -----
// port-level checks of the laplacian filter and their bind
module lap3x3_checker import lap3x3_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_we,
	input logic [CFG_W-1:0] cfg_data,
	input logic             in_valid,
	input logic             in_ready,
	input logic             res_valid,
	input logic             res_ready,
	input pix_t             res_filtered,
	input logic             res_last
);

	localparam int RST_SIDE = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;

	logic [31:0] side_q;
	logic [31:0] side_new;
	logic [31:0] done_q;
	logic [31:0] owed_q;
	logic [31:0] total;
	logic        in_hs, res_hs;

	assign in_hs  = in_valid && in_ready;
	assign res_hs = res_valid && res_ready;
	assign total  = side_q * side_q;

	always_comb begin
		if (cfg_data == '0) begin
			side_new = 32'd1;
		end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
			side_new = 32'(MAX_SIDE);
		end else begin
			side_new = 32'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 32'(RST_SIDE);
			done_q <= '0;
			owed_q <= '0;
		end else begin
			if (cfg_we) begin
				side_q <= side_new;
				done_q <= '0;
			end else if (res_hs) begin
				done_q <= res_last ? '0 : done_q + 32'd1;
			end
			owed_q <= owed_q + 32'(in_hs) - 32'(res_hs);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_filtered) && $stable(res_last))
		else $error("result changed while stalled");

	// every result answers an earlier transaction
	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_hs |-> owed_q != 32'd0)
		else $error("more results than accepted transactions");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_hs && res_last |-> done_q + 32'd1 == total)
		else $error("frame_last not on the final pixel of the frame");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_hs && !res_last |-> done_q + 32'd1 < total)
		else $error("frame ran past side squared results");

endmodule

bind laplacian_3x3_filter lap3x3_checker #(.MAX_SIDE(MAX_SIDE)) u_lap3x3_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_data     (cfg_data),
	.in_valid     (stream.valid),
	.in_ready     (stream.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_filtered (result.filtered),
	.res_last     (result.frame_last)
);
